@@ design/slx_pkg.sv @@
// slx_pkg: shared types, token kind codes, error codes and keyword table
// for the script lexer. No dependencies.
`default_nettype none
package slx_pkg;

	localparam int OFFSET_BITS_DEF = 20;
	localparam int WORD_BYTES_DEF  = 8;
	localparam int Q_DEPTH         = 4;
	localparam int KW_COUNT        = 21;

	typedef enum logic [3:0] {
		M_IDLE, M_EQ, M_TILDE, M_LT, M_GT, M_DOT1, M_DOT2, M_MINUS,
		M_COMMENT, M_WORD, M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_STRING
	} mode_t;

	// token kinds
	localparam logic [5:0] K_ERR    = 6'd0;
	localparam logic [5:0] K_ADD    = 6'd0;
	localparam logic [5:0] K_SUB    = 6'd1;
	localparam logic [5:0] K_MUL    = 6'd2;
	localparam logic [5:0] K_DIV    = 6'd3;
	localparam logic [5:0] K_MOD    = 6'd4;
	localparam logic [5:0] K_POW    = 6'd5;
	localparam logic [5:0] K_LEN    = 6'd6;
	localparam logic [5:0] K_EQ     = 6'd7;
	localparam logic [5:0] K_NE     = 6'd8;
	localparam logic [5:0] K_LE     = 6'd9;
	localparam logic [5:0] K_GE     = 6'd10;
	localparam logic [5:0] K_LT     = 6'd11;
	localparam logic [5:0] K_GT     = 6'd12;
	localparam logic [5:0] K_ASSIGN = 6'd13;
	localparam logic [5:0] K_LPAREN = 6'd14;
	localparam logic [5:0] K_RPAREN = 6'd15;
	localparam logic [5:0] K_LBRACE = 6'd16;
	localparam logic [5:0] K_RBRACE = 6'd17;
	localparam logic [5:0] K_LBRACK = 6'd18;
	localparam logic [5:0] K_RBRACK = 6'd19;
	localparam logic [5:0] K_SEMI   = 6'd20;
	localparam logic [5:0] K_COLON  = 6'd21;
	localparam logic [5:0] K_COMMA  = 6'd22;
	localparam logic [5:0] K_DOT    = 6'd23;
	localparam logic [5:0] K_CONCAT = 6'd24;
	localparam logic [5:0] K_DOTS   = 6'd25;
	localparam logic [5:0] K_KW0    = 6'd26;
	localparam logic [5:0] K_NUMBER = 6'd47;
	localparam logic [5:0] K_STRING = 6'd48;
	localparam logic [5:0] K_IDENT  = 6'd49;
	localparam logic [5:0] K_EOF    = 6'd50;

	// error codes
	localparam logic [1:0] E_NONE   = 2'd0;
	localparam logic [1:0] E_TILDE  = 2'd1;
	localparam logic [1:0] E_STRING = 2'd2;
	localparam logic [1:0] E_CHAR   = 2'd3;

	// keywords, right-aligned, first character in the highest used byte
	localparam logic [63:0] KW_VAL [KW_COUNT] = '{
		64'("and"), 64'("break"), 64'("do"), 64'("else"), 64'("elseif"),
		64'("end"), 64'("false"), 64'("for"), 64'("function"), 64'("if"),
		64'("in"), 64'("local"), 64'("nil"), 64'("not"), 64'("or"),
		64'("repeat"), 64'("return"), 64'("then"), 64'("true"), 64'("until"),
		64'("while")
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd5, 4'd2, 4'd4, 4'd6, 4'd3, 4'd5, 4'd3, 4'd8, 4'd2,
		4'd2, 4'd5, 4'd3, 4'd3, 4'd2, 4'd6, 4'd6, 4'd4, 4'd4, 4'd5, 4'd5
	};

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
	endfunction

	// w holds the first eight word bytes, first byte in the top byte
	function automatic logic [5:0] word_kind(input logic [63:0] w, input logic [3:0] n);
		logic [5:0]  kind;
		logic [63:0] head;
		kind = K_IDENT;
		head = w >> (7'd64 - {n, 3'b000});
		for (int k = 0; k < KW_COUNT; k++) begin
			if (n == KW_LEN[k] && head == KW_VAL[k])
				kind = K_KW0 + 6'(k);
		end
		return kind;
	endfunction

	// single-character operators; bit 6 flags a match
	function automatic logic [6:0] single_op(input logic [7:0] b);
		unique case (b)
			"+": return {1'b1, K_ADD};
			"*": return {1'b1, K_MUL};
			"/": return {1'b1, K_DIV};
			"%": return {1'b1, K_MOD};
			"^": return {1'b1, K_POW};
			"#": return {1'b1, K_LEN};
			"(": return {1'b1, K_LPAREN};
			")": return {1'b1, K_RPAREN};
			"{": return {1'b1, K_LBRACE};
			"}": return {1'b1, K_RBRACE};
			"[": return {1'b1, K_LBRACK};
			"]": return {1'b1, K_RBRACK};
			";": return {1'b1, K_SEMI};
			":": return {1'b1, K_COLON};
			",": return {1'b1, K_COMMA};
			default: return {1'b0, K_ERR};
		endcase
	endfunction

endpackage
`default_nettype wire

@@ design/slx_front.sv @@
// slx_front: lexer state machine; takes one byte per transfer and builds a
// bundle of up to three results. Depends on slx_pkg.
`default_nettype none
module slx_front import slx_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int WORD_BYTES  = WORD_BYTES_DEF,
	localparam int EW = 8 + 2 * OFFSET_BITS,
	localparam int BW = 2 + 3 * EW
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,
	input  wire logic [7:0]    text_byte,
	input  wire logic          end_of_text,
	output logic               push,
	output logic [BW-1:0]      bundle
);

	localparam int WI = $clog2(WORD_BYTES);
	localparam logic [OFFSET_BITS-1:0] OMAX = '1;

	mode_t                  mode_q, m;
	logic [OFFSET_BITS-1:0] offset_q, origin_q, run_q;
	logic                   dq_q, ep_q;
	logic [7:0]             word_q [WORD_BYTES];

	logic [OFFSET_BITS-1:0] o, r, ofs_n;
	logic                   dq, ep, cons, wb_we;
	logic [WI-1:0]          wb_idx;
	logic [1:0]             n;
	logic [5:0]             rk [3];
	logic [1:0]             re [3];
	logic [OFFSET_BITS-1:0] rs [3], rl [3];
	logic [63:0]            w;
	logic [5:0]             wkind;
	logic [6:0]             sop;
	logic [OFFSET_BITS:0]   dot;
	logic                   eot, dig, let_c;
	logic [7:0]             b;

	function automatic logic [OFFSET_BITS-1:0] sat(input logic [OFFSET_BITS-1:0] v);
		return (v == OMAX) ? v : v + 1'b1;
	endfunction

	always_comb begin
		for (int i = 0; i < 8; i++)
			w[63 - 8 * i -: 8] = word_q[i];
		wkind = (run_q > OFFSET_BITS'(8)) ? K_IDENT : word_kind(w, run_q[3:0]);
	end

	always_comb begin
		b     = text_byte;
		eot   = end_of_text;
		dig   = !eot && is_digit(b);
		let_c = !eot && is_letter(b);
		sop   = single_op(b);
		m     = mode_q;
		o     = origin_q;
		r     = run_q;
		dq    = dq_q;
		ep    = ep_q;
		cons  = 1'b0;
		wb_we = 1'b0;
		wb_idx = run_q[WI-1:0];
		n     = 2'd0;
		dot   = '0;
		for (int i = 0; i < 3; i++) begin
			rk[i] = K_ERR; rs[i] = '0; rl[i] = '0; re[i] = E_NONE;
		end

		// settle the pending token
		unique case (mode_q)
			M_EQ, M_TILDE, M_LT, M_GT: begin
				m = M_IDLE;
				rs[n] = o;
				re[n] = E_NONE;
				if (!eot && b == "=") begin
					rl[n] = OFFSET_BITS'(2);
					cons = 1'b1;
					unique case (mode_q)
						M_EQ:    rk[n] = K_EQ;
						M_TILDE: rk[n] = K_NE;
						M_LT:    rk[n] = K_LE;
						default: rk[n] = K_GE;
					endcase
				end else begin
					rl[n] = OFFSET_BITS'(1);
					unique case (mode_q)
						M_EQ:    rk[n] = K_ASSIGN;
						M_TILDE: begin rk[n] = K_ERR; re[n] = E_TILDE; end
						M_LT:    rk[n] = K_LT;
						default: rk[n] = K_GT;
					endcase
				end
				n = n + 1'b1;
			end
			M_DOT1: begin
				if (!eot && b == ".") begin
					m = M_DOT2; r = OFFSET_BITS'(2); cons = 1'b1;
				end else begin
					m = M_IDLE;
					rk[n] = K_DOT; rs[n] = o; rl[n] = OFFSET_BITS'(1); n = n + 1'b1;
				end
			end
			M_DOT2: begin
				m = M_IDLE;
				rs[n] = o;
				if (!eot && b == ".") begin
					rk[n] = K_DOTS; rl[n] = OFFSET_BITS'(3); cons = 1'b1;
				end else begin
					rk[n] = K_CONCAT; rl[n] = OFFSET_BITS'(2);
				end
				n = n + 1'b1;
			end
			M_MINUS: begin
				if (!eot && b == "-") begin
					m = M_COMMENT; cons = 1'b1;
				end else begin
					m = M_IDLE;
					rk[n] = K_SUB; rs[n] = o; rl[n] = OFFSET_BITS'(1); n = n + 1'b1;
				end
			end
			M_COMMENT: begin
				if (eot || b == "\n")
					m = M_IDLE;
				cons = 1'b1;
			end
			M_WORD: begin
				if (let_c || dig) begin
					wb_we = (run_q < OFFSET_BITS'(WORD_BYTES));
					r = sat(r);
					cons = 1'b1;
				end else begin
					m = M_IDLE;
					rk[n] = wkind; rs[n] = o; rl[n] = r; n = n + 1'b1;
				end
			end
			M_NUM_INT, M_NUM_FRAC: begin
				if (dig) begin
					r = sat(r); cons = 1'b1;
				end else if (!eot && b == "." && mode_q == M_NUM_INT) begin
					m = M_NUM_DOT; r = sat(r); cons = 1'b1;
				end else begin
					m = M_IDLE;
					rk[n] = K_NUMBER; rs[n] = o; rl[n] = r; n = n + 1'b1;
				end
			end
			M_NUM_DOT: begin
				if (dig) begin
					m = M_NUM_FRAC; r = sat(r); cons = 1'b1;
				end else begin
					rk[n] = K_NUMBER; rs[n] = o; rl[n] = r - 1'b1; n = n + 1'b1;
					dot = {1'b0, o} + {1'b0, r} - 1'b1;
					m = M_DOT1;
					o = dot[OFFSET_BITS] ? OMAX : dot[OFFSET_BITS-1:0];
					r = OFFSET_BITS'(1);
				end
			end
			M_STRING: begin
				if (eot || (b == "\n" && !ep)) begin
					m = M_IDLE; ep = 1'b0;
					rk[n] = K_ERR; rs[n] = o; rl[n] = r; re[n] = E_STRING;
					n = n + 1'b1;
				end else begin
					r = sat(r);
					cons = 1'b1;
					if (ep) begin
						ep = 1'b0;
					end else if (b == "\\") begin
						ep = 1'b1;
					end else if (b == (dq ? "\"" : "'")) begin
						m = M_IDLE;
						rk[n] = K_STRING; rs[n] = o; rl[n] = r; n = n + 1'b1;
					end
				end
			end
			default: m = M_IDLE;
		endcase

		// a dot left behind by a number
		if (!cons && m == M_DOT1) begin
			if (!eot && b == ".") begin
				m = M_DOT2; r = OFFSET_BITS'(2); cons = 1'b1;
			end else begin
				m = M_IDLE;
				rk[n] = K_DOT; rs[n] = o; rl[n] = OFFSET_BITS'(1); n = n + 1'b1;
			end
		end

		// start a new token
		if (!cons && !eot) begin
			if (sop[6]) begin
				rk[n] = sop[5:0]; rs[n] = offset_q; rl[n] = OFFSET_BITS'(1);
				n = n + 1'b1;
			end else if (b == 8'h00) begin
				rk[n] = K_EOF; rs[n] = offset_q; rl[n] = OFFSET_BITS'(1);
				n = n + 1'b1;
			end else if (b == "-" || b == "=" || b == "~" || b == "<" || b == ">"
					|| b == "." || b == "\"" || b == "'" || let_c || dig) begin
				o = offset_q;
				r = OFFSET_BITS'(1);
				priority if (b == "-")  m = M_MINUS;
				else if (b == "=")      m = M_EQ;
				else if (b == "~")      m = M_TILDE;
				else if (b == "<")      m = M_LT;
				else if (b == ">")      m = M_GT;
				else if (b == ".")      m = M_DOT1;
				else if (let_c) begin
					m = M_WORD; wb_we = 1'b1; wb_idx = '0;
				end else if (dig)       m = M_NUM_INT;
				else begin
					m = M_STRING; dq = (b == "\""); ep = 1'b0;
				end
			end else if (!(b == "\n" || b == "\r" || b == " " || b == "\t")) begin
				rk[n] = K_ERR; rs[n] = offset_q; rl[n] = OFFSET_BITS'(1); re[n] = E_CHAR;
				n = n + 1'b1;
			end
		end

		ofs_n = sat(offset_q);
		if (eot) begin
			rk[n] = K_EOF; rs[n] = offset_q; rl[n] = '0; re[n] = E_NONE;
			n = n + 1'b1;
			m = M_IDLE; o = '0; r = '0; dq = 1'b0; ep = 1'b0; ofs_n = '0;
			wb_we = 1'b0;
		end

		push   = take && (n != 2'd0);
		bundle = {n, rk[2], re[2], rs[2], rl[2], rk[1], re[1], rs[1], rl[1],
			rk[0], re[0], rs[0], rl[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			offset_q <= '0;
			origin_q <= '0;
			run_q    <= '0;
			dq_q     <= 1'b0;
			ep_q     <= 1'b0;
		end else if (take) begin
			mode_q   <= m;
			offset_q <= ofs_n;
			origin_q <= o;
			run_q    <= r;
			dq_q     <= dq;
			ep_q     <= ep;
		end
	end

	always_ff @(posedge clk) begin
		if (take && wb_we)
			word_q[wb_idx] <= b;
	end

endmodule
`default_nettype wire

@@ design/slx_queue.sv @@
// slx_queue: small FIFO of result bundles between front and back.
// Depends on slx_pkg.
`default_nettype none
module slx_queue import slx_pkg::*; #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output logic              empty,
	output logic              full
);

	localparam int PW = $clog2(Q_DEPTH);

	logic [W-1:0]  mem_q [Q_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (PW+1)'(Q_DEPTH));
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

endmodule
`default_nettype wire

@@ design/slx_back.sv @@
// slx_back: unpacks queued bundles into single results on a registered
// output. Depends on slx_pkg.
`default_nettype none
module slx_back import slx_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	localparam int EW = 8 + 2 * OFFSET_BITS,
	localparam int BW = 2 + 3 * EW
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [BW-1:0]          head,
	input  wire logic                   empty,
	output logic                        pop,
	output logic                        token_valid,
	input  wire logic                   token_ready,
	output logic [5:0]                  token_kind,
	output logic [OFFSET_BITS-1:0]      token_start,
	output logic [OFFSET_BITS-1:0]      token_length,
	output logic [1:0]                  error_code,
	output logic                        last_of_run
);

	logic [1:0]    sel_q;
	logic          pull, last;
	logic [EW-1:0] ent;
	logic [1:0]    cnt;

	assign cnt  = head[BW-1 -: 2];
	assign ent  = head[sel_q * EW +: EW];
	assign pull = !token_valid || token_ready;
	assign last = (sel_q == cnt - 1'b1);
	assign pop  = pull && !empty && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_valid <= 1'b0;
			sel_q       <= '0;
		end else if (pull) begin
			token_valid <= !empty;
			if (!empty)
				sel_q <= last ? 2'd0 : sel_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pull && !empty) begin
			token_kind   <= ent[EW-1 -: 6];
			error_code   <= ent[EW-7 -: 2];
			token_start  <= ent[2*OFFSET_BITS-1 -: OFFSET_BITS];
			token_length <= ent[OFFSET_BITS-1:0];
			last_of_run  <= last;
		end
	end

endmodule
`default_nettype wire

@@ design/script_lexer_core.sv @@
// script_lexer_core: top level of the streaming lexer; front, bundle queue
// and back. Depends on slx_pkg, slx_front, slx_queue, slx_back.
//
//  channel | signals                                        | dir
//  text    | text_valid, text_ready, text_byte, end_of_text | in
//  token   | token_valid, token_ready, token_kind,          | out
//          | token_start, token_length, error_code, last_of_run
//
// One byte is taken per cycle while the four-entry bundle queue has room.
// Each byte yields up to three results; the back drains one result per
// cycle while token_ready allows it, so a byte making k results takes k output transfers.
// A byte's results pass through the bundle queue, then the back's output register.
// Reset clears lexer state, queue and output valid; the word buffer is not reset.
`default_nettype none
module script_lexer_core import slx_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int WORD_BYTES  = WORD_BYTES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   text_valid,
	output logic                        text_ready,
	input  wire logic [7:0]             text_byte,
	input  wire logic                   end_of_text,
	output logic                        token_valid,
	input  wire logic                   token_ready,
	output logic [5:0]                  token_kind,
	output logic [OFFSET_BITS-1:0]      token_start,
	output logic [OFFSET_BITS-1:0]      token_length,
	output logic [1:0]                  error_code,
	output logic                        last_of_run
);

	localparam int EW = 8 + 2 * OFFSET_BITS;
	localparam int BW = 2 + 3 * EW;

	logic          q_push, q_pop, q_empty, q_full, take;
	logic [BW-1:0] q_wdata, q_rdata;

	assign text_ready = !q_full;
	assign take       = text_valid && text_ready;

	slx_front #(.OFFSET_BITS(OFFSET_BITS), .WORD_BYTES(WORD_BYTES)) u_front (
		.clk, .arst_n, .take, .text_byte, .end_of_text,
		.push(q_push), .bundle(q_wdata)
	);

	slx_queue #(.W(BW)) u_queue (
		.clk, .arst_n, .push(q_push), .wdata(q_wdata), .pop(q_pop),
		.rdata(q_rdata), .empty(q_empty), .full(q_full)
	);

	slx_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
		.clk, .arst_n, .head(q_rdata), .empty(q_empty), .pop(q_pop),
		.token_valid, .token_ready, .token_kind, .token_start, .token_length,
		.error_code, .last_of_run
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("bundle pushed into full queue");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("bundle popped from empty queue");

	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && error_code != E_NONE |-> token_kind == K_ERR)
		else $error("error result with nonzero kind");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_kind == K_EOF && token_length == '0 |-> last_of_run)
		else $error("end-of-text eof not last of run");

endmodule
`default_nettype wire

@@ tb/sv/tb_script_lexer_core.sv @@
// tb_script_lexer_core: self-checking bench for the streaming script lexer.
// Feeds directed and random source text and checks every token against a
// built-in token predictor. Depends on slx_pkg and script_lexer_core.
`default_nettype none
module tb_script_lexer_core;
	timeunit 1ns;
	timeprecision 1ps;
	import slx_pkg::*;

	localparam int unsigned OFS_LIMIT = (1 << 20) - 1;

	typedef struct packed {
		logic [5:0]  kind;
		logic [19:0] start;
		logic [19:0] len;
		logic [1:0]  err;
		logic        last;
	} token_t;

	class token_scoreboard;
		token_t      awaited[$];
		token_t      step_toks[$];
		mode_t       mode;
		byte unsigned wbuf[8];
		int unsigned ofs, origin, run_len;
		bit          dquote, esc;
		int          errors;
		string       kw[21] = '{"and", "break", "do", "else", "elseif", "end", "false",
			"for", "function", "if", "in", "local", "nil", "not", "or", "repeat",
			"return", "then", "true", "until", "while"};

		function void clear_state();
			mode = M_IDLE;
			ofs = 0;
			origin = 0;
			run_len = 0;
			dquote = 0;
			esc = 0;
		endfunction

		function int unsigned sat(int unsigned v);
			return (v < OFS_LIMIT) ? v + 1 : v;
		endfunction

		function bit digit(int b);
			return b >= "0" && b <= "9";
		endfunction

		function bit letter(int b);
			return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
		endfunction

		function void add(logic [5:0] k, int unsigned s, int unsigned l, logic [1:0] e);
			token_t t;
			if (step_toks.size() >= 3)
				return;
			t.kind = k;
			t.start = s[19:0];
			t.len = l[19:0];
			t.err = e;
			t.last = 0;
			step_toks.push_back(t);
		endfunction

		function logic [5:0] classify_word();
			bit hit;
			if (run_len > 8)
				return K_IDENT;
			for (int k = 0; k < 21; k++) begin
				if (kw[k].len() == run_len) begin
					hit = 1;
					for (int i = 0; i < kw[k].len(); i++)
						if (wbuf[i] != kw[k][i])
							hit = 0;
					if (hit)
						return K_KW0 + 6'(k);
				end
			end
			return K_IDENT;
		endfunction

		function void open_tok(mode_t m, int unsigned p);
			mode = m;
			origin = p;
			run_len = 1;
		endfunction

		function void idle_byte(int b, int unsigned p);
			case (b)
				"+": add(K_ADD, p, 1, E_NONE);
				"*": add(K_MUL, p, 1, E_NONE);
				"/": add(K_DIV, p, 1, E_NONE);
				"%": add(K_MOD, p, 1, E_NONE);
				"^": add(K_POW, p, 1, E_NONE);
				"#": add(K_LEN, p, 1, E_NONE);
				"(": add(K_LPAREN, p, 1, E_NONE);
				")": add(K_RPAREN, p, 1, E_NONE);
				"{": add(K_LBRACE, p, 1, E_NONE);
				"}": add(K_RBRACE, p, 1, E_NONE);
				"[": add(K_LBRACK, p, 1, E_NONE);
				"]": add(K_RBRACK, p, 1, E_NONE);
				";": add(K_SEMI, p, 1, E_NONE);
				":": add(K_COLON, p, 1, E_NONE);
				",": add(K_COMMA, p, 1, E_NONE);
				"-": open_tok(M_MINUS, p);
				"=": open_tok(M_EQ, p);
				"~": open_tok(M_TILDE, p);
				"<": open_tok(M_LT, p);
				">": open_tok(M_GT, p);
				".": open_tok(M_DOT1, p);
				0: add(K_EOF, p, 1, E_NONE);
				-1, 10, 13, 32, 9: ;
				34, 39: begin
					open_tok(M_STRING, p);
					dquote = (b == 34);
					esc = 0;
				end
				default: begin
					if (letter(b)) begin
						open_tok(M_WORD, p);
						wbuf[0] = b[7:0];
					end else if (digit(b))
						open_tok(M_NUM_INT, p);
					else
						add(K_ERR, p, 1, E_CHAR);
				end
			endcase
		endfunction

		// returns 0 when a pending token was settled and b must be offered again
		function bit feed(int b, int unsigned p);
			int unsigned dot;
			case (mode)
				M_EQ, M_TILDE, M_LT, M_GT: begin
					mode_t m;
					m = mode;
					mode = M_IDLE;
					if (b == "=") begin
						case (m)
							M_EQ: add(K_EQ, origin, 2, E_NONE);
							M_TILDE: add(K_NE, origin, 2, E_NONE);
							M_LT: add(K_LE, origin, 2, E_NONE);
							default: add(K_GE, origin, 2, E_NONE);
						endcase
						return 1;
					end
					case (m)
						M_EQ: add(K_ASSIGN, origin, 1, E_NONE);
						M_TILDE: add(K_ERR, origin, 1, E_TILDE);
						M_LT: add(K_LT, origin, 1, E_NONE);
						default: add(K_GT, origin, 1, E_NONE);
					endcase
					return 0;
				end
				M_DOT1: begin
					if (b == ".") begin
						mode = M_DOT2;
						run_len = 2;
						return 1;
					end
					mode = M_IDLE;
					add(K_DOT, origin, 1, E_NONE);
					return 0;
				end
				M_DOT2: begin
					mode = M_IDLE;
					if (b == ".") begin
						add(K_DOTS, origin, 3, E_NONE);
						return 1;
					end
					add(K_CONCAT, origin, 2, E_NONE);
					return 0;
				end
				M_MINUS: begin
					if (b == "-") begin
						mode = M_COMMENT;
						return 1;
					end
					mode = M_IDLE;
					add(K_SUB, origin, 1, E_NONE);
					return 0;
				end
				M_COMMENT: begin
					if (b < 0) begin
						mode = M_IDLE;
						return 0;
					end
					if (b == 10)
						mode = M_IDLE;
					return 1;
				end
				M_WORD: begin
					if (letter(b) || digit(b)) begin
						if (run_len < 8)
							wbuf[run_len] = b[7:0];
						run_len = sat(run_len);
						return 1;
					end
					mode = M_IDLE;
					add(classify_word(), origin, run_len, E_NONE);
					return 0;
				end
				M_NUM_INT, M_NUM_FRAC: begin
					if (digit(b)) begin
						run_len = sat(run_len);
						return 1;
					end
					if (b == "." && mode == M_NUM_INT) begin
						mode = M_NUM_DOT;
						run_len = sat(run_len);
						return 1;
					end
					mode = M_IDLE;
					add(K_NUMBER, origin, run_len, E_NONE);
					return 0;
				end
				M_NUM_DOT: begin
					if (digit(b)) begin
						mode = M_NUM_FRAC;
						run_len = sat(run_len);
						return 1;
					end
					// number ends before the dot; the dot starts its own token
					add(K_NUMBER, origin, run_len - 1, E_NONE);
					dot = origin + run_len - 1;
					if (dot > OFS_LIMIT)
						dot = OFS_LIMIT;
					open_tok(M_DOT1, dot);
					return 0;
				end
				M_STRING: begin
					if (b < 0 || (b == 10 && !esc)) begin
						mode = M_IDLE;
						esc = 0;
						add(K_ERR, origin, run_len, E_STRING);
						return 0;
					end
					run_len = sat(run_len);
					if (esc)
						esc = 0;
					else if (b == 92)
						esc = 1;
					else if (b == (dquote ? 34 : 39)) begin
						mode = M_IDLE;
						add(K_STRING, origin, run_len, E_NONE);
					end
					return 1;
				end
				default: begin
					mode = M_IDLE;
					idle_byte(b, p);
					return 1;
				end
			endcase
		endfunction

		function void note_input(logic [7:0] b, logic eot);
			step_toks.delete();
			if (eot) begin
				while (!feed(-1, ofs));
				add(K_EOF, ofs, 0, E_NONE);
				clear_state();
			end else begin
				while (!feed(int'(b), ofs));
				ofs = sat(ofs);
			end
			if (step_toks.size() > 0)
				step_toks[step_toks.size() - 1].last = 1;
			foreach (step_toks[i])
				awaited.push_back(step_toks[i]);
		endfunction

		task report(string msg);
			$display("%0t ERROR %s", $realtime, msg);
			errors++;
		endtask

		task check_result(token_t got);
			token_t exp;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected token kind %0d start %0d", got.kind, got.start));
				return;
			end
			exp = awaited.pop_front();
			if (got !== exp)
				report($sformatf("got k%0d s%0d l%0d e%0d last%0d, want k%0d s%0d l%0d e%0d last%0d",
					got.kind, got.start, got.len, got.err, got.last,
					exp.kind, exp.start, exp.len, exp.err, exp.last));
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        text_valid = 0;
	logic        text_ready;
	logic [7:0]  text_byte = 0;
	logic        end_of_text = 0;
	logic        token_valid;
	logic        token_ready = 0;
	logic [5:0]  token_kind;
	logic [19:0] token_start;
	logic [19:0] token_length;
	logic [1:0]  error_code;
	logic        last_of_run;

	token_scoreboard sb = new();
	bit calm = 0;
	int sent = 0;

	script_lexer_core uut (
		.clk(clk), .arst_n(arst_n),
		.text_valid(text_valid), .text_ready(text_ready),
		.text_byte(text_byte), .end_of_text(end_of_text),
		.token_valid(token_valid), .token_ready(token_ready),
		.token_kind(token_kind), .token_start(token_start),
		.token_length(token_length), .error_code(error_code),
		.last_of_run(last_of_run)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		token_ready <= calm || ($urandom_range(0, 99) >= 30);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (text_valid && text_ready)
				sb.note_input(text_byte, end_of_text);
			if (token_valid && token_ready)
				sb.check_result({token_kind, token_start, token_length, error_code, last_of_run});
		end
	end

	task send_item(logic [7:0] b, logic eot);
		if (!calm && $urandom_range(0, 99) < 20) begin
			text_valid <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		text_valid <= 1;
		text_byte <= b;
		end_of_text <= eot;
		do @(posedge clk); while (!text_ready);
		sent++;
	endtask

	task send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 0);
	endtask

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26)
			return 8'("a" + r);
		if (r < 52)
			return 8'("A" + r - 26);
		return "_";
	endfunction

	task send_fragment();
		string ops;
		string w;
		int n;
		logic [7:0] q;
		ops = "+-*/%^#(){}[];:,=~<>.";
		case ($urandom_range(0, 19))
			0, 1, 2: begin
				w = sb.kw[$urandom_range(0, 20)];
				send_text(w);
				send_item(" ", 0);
			end
			3, 4: begin
				send_item(rand_letter(), 0);
				n = $urandom_range(0, 11);
				repeat (n)
					send_item($urandom_range(0, 2) == 0 ? 8'("0" + $urandom_range(0, 9))
						: rand_letter(), 0);
			end
			5, 6: begin
				repeat ($urandom_range(1, 3)) send_item(8'("0" + $urandom_range(0, 9)), 0);
				if ($urandom_range(0, 1)) begin
					send_item(".", 0);
					repeat ($urandom_range(0, 2)) send_item(8'("0" + $urandom_range(0, 9)), 0);
				end
			end
			7, 8: begin
				q = $urandom_range(0, 1) ? 8'd34 : 8'd39;
				send_item(q, 0);
				repeat ($urandom_range(0, 5)) begin
					if ($urandom_range(0, 4) == 0) begin
						send_item(8'd92, 0);
						send_item(8'($urandom_range(0, 255)), 0);
					end else
						send_item(8'($urandom_range(32, 126)), 0);
				end
				if ($urandom_range(0, 9) != 0)
					send_item(q, 0);
			end
			9, 10, 11: begin
				send_item(ops[$urandom_range(0, ops.len() - 1)], 0);
				if ($urandom_range(0, 2) == 0)
					send_item($urandom_range(0, 1) ? 8'("=") : 8'("."), 0);
			end
			12: begin
				send_text("--");
				repeat ($urandom_range(0, 4)) send_item(rand_letter(), 0);
				send_item(8'd10, 0);
			end
			13, 14, 15: send_item($urandom_range(0, 1) ? 8'd32 : 8'd10, 0);
			16, 17: send_item(8'($urandom_range(0, 255)), 0);
			18: send_item(8'($urandom_range(0, 255)), 1);
			default: send_item(8'd9, 0);
		endcase
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// operators, keywords, words, numbers, strings, comments and errors
		send_text("elseif function abcdefghij 12.5 3..4 ");
		send_text("== ~= <= >= < > ~ ... .. -x --c\n[@");
		send_item(8'd0, 0);
		send_text("\"a\\\"b\" 'c\\\n' 'u\n");
		send_item(8'hFF, 0);
		send_text("'open");
		send_item(8'hA5, 1);
		while (sent < 210) begin
			calm = (sent >= 100 && sent < 150);
			send_fragment();
		end
		calm = 0;
		send_item(8'h5A, 1);
		text_valid <= 0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#400000;
		$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
design/slx_pkg.sv
design/slx_front.sv
design/slx_queue.sv
design/slx_back.sv
design/script_lexer_core.sv
tb/sv/tb_script_lexer_core.sv
